/* rtl/core/srt_pkg.sv */
`default_nettype none
package srt_pkg;
    localparam int MAX_REGIONS = 16;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_BITS = 39;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_W = ADDR_BITS - PAGE_SHIFT;
    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    typedef enum logic [1:0] {
        FUNC_MAP   = 2'd0,
        FUNC_FIND  = 2'd1,
        FUNC_CHECK = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_WINDOW   = 3'd1,
        ST_OVERLAP  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_DENIED   = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]           func;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] length;
        logic [2:0]           flags;
        logic                 is_write;
    } in_word_t;

    typedef struct packed {
        logic [2:0]           status;
        logic                 hit;
        logic [3:0]           hit_index;
        logic [ADDR_BITS-1:0] hit_start;
        logic [ADDR_BITS-1:0] hit_end;
        logic [2:0]           hit_flags;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_CHK_STEP,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic scan;
        logic shift;
        logic write;
        logic chk_start;
        logic chk_step;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic     early;
        logic     scan_end;
        logic     shift_end;
        logic     chk_done;
        logic [1:0] func;
    } stat_t;
endpackage
`default_nettype wire

/* rtl/core/srt_ctrl.sv */
`default_nettype none
module srt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic          out_busy,
    input  wire srt_pkg::stat_t st,
    output srt_pkg::cmd_t      cmd,
    output logic               idle
);
    import srt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        idle = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (st.func == FUNC_CLEAR)
                    state_next = S_DONE;
                else if (st.func == FUNC_CHECK)
                    state_next = S_CHK_STEP;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // window or overlap already decided, stop scanning
                if (st.early)
                    state_next = S_DONE;
                else
                begin
                    cmd.scan = 1'b1;
                    if (st.scan_end)
                        state_next = (st.func == FUNC_MAP) ? S_SHIFT : S_DONE;
                end
            end
            S_SHIFT:
            begin
                // full table is flagged on the last scan cycle
                if (st.early)
                    state_next = S_DONE;
                else
                begin
                    cmd.shift = 1'b1;
                    if (st.shift_end)
                        state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
                state_next = S_DONE;
            end
            S_CHK_STEP:
            begin
                cmd.chk_step = 1'b1;
                if (st.chk_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/core/srt_dp.sv */
`default_nettype none
module srt_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire srt_pkg::cmd_t                  cmd,
    input  wire srt_pkg::in_word_t              in_word,
    input  wire logic [srt_pkg::ADDR_BITS-1:0]  win_low,
    input  wire logic [srt_pkg::ADDR_BITS-1:0]  win_high,
    output srt_pkg::stat_t                      st,
    output srt_pkg::out_word_t                  res
);
    import srt_pkg::*;

    logic [PAGE_W-1:0] sp_mem [MAX_REGIONS];
    logic [PAGE_W-1:0] ep_mem [MAX_REGIONS];
    logic [2:0]        fl_mem [MAX_REGIONS];

    logic [CNT_W-1:0]  count_reg;
    in_word_t          req_reg;
    logic [PAGE_W-1:0] sp_reg, ep_reg;
    logic              early_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic              pos_found_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  fidx_reg;
    logic [ADDR_BITS:0] cur_reg;
    logic [ADDR_BITS:0] end_reg;
    logic [CNT_W:0]    steps_reg;
    logic              chk_done_reg;
    out_word_t         res_reg;

    // map page range
    logic [ADDR_BITS:0] sum;
    logic [PAGE_W:0]    ep_c;
    logic [ADDR_BITS:0] sp_byte;
    assign sum = {1'b0, req_reg.addr} + {1'b0, req_reg.length};
    assign ep_c = {1'b0, sum[ADDR_BITS-1:PAGE_SHIFT]}
                  + {{PAGE_W{1'b0}}, |sum[PAGE_SHIFT-1:0]};
    assign sp_byte = {1'b0, req_reg.addr[ADDR_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

    // window checks for map and check
    logic      map_bad, chk_bad;
    out_word_t dec_res;
    assign map_bad = (req_reg.func == FUNC_MAP) &&
                     (sum[ADDR_BITS] ||
                      !({1'b0, req_reg.addr[ADDR_BITS-1:PAGE_SHIFT]} < ep_c) ||
                      sp_byte < {1'b0, win_low} ||
                      ep_c > {1'b0, win_high[ADDR_BITS-1:PAGE_SHIFT]});
    assign chk_bad = (req_reg.func == FUNC_CHECK) &&
                     (sum[ADDR_BITS] || sum[ADDR_BITS-1:0] <= req_reg.addr ||
                      req_reg.addr < win_low || sum[ADDR_BITS-1:0] > win_high);

    always_comb
    begin
        dec_res = '0;
        if (map_bad || chk_bad)
            dec_res.status = ST_WINDOW;
    end

    logic [IDX_W-1:0]  ix;
    logic [PAGE_W-1:0] e_sp, e_ep;
    logic [2:0]        e_fl;
    logic              in_tab;
    assign ix = idx_reg[IDX_W-1:0];
    assign in_tab = idx_reg < count_reg;
    assign e_sp = sp_mem[ix];
    assign e_ep = ep_mem[ix];
    assign e_fl = fl_mem[ix];

    logic [PAGE_W-1:0] find_pg, cur_pg;
    assign find_pg = req_reg.addr[ADDR_BITS-1:PAGE_SHIFT];
    assign cur_pg = cur_reg[ADDR_BITS-1:PAGE_SHIFT];

    // pj is the entry below idx, the source when an entry shifts up one place
    logic [IDX_W-1:0] pj;
    logic [CNT_W-1:0] pj1;
    assign pj1 = idx_reg - CNT_W'(1);
    assign pj = pj1[IDX_W-1:0];

    logic chk_hold;
    assign chk_hold = in_tab && (e_sp <= cur_pg) && (cur_pg < e_ep);

    always_ff @(posedge clk)
    begin
        if (cmd.shift && idx_reg > pos_reg)
        begin
            sp_mem[ix] <= sp_mem[pj];
            ep_mem[ix] <= ep_mem[pj];
            fl_mem[ix] <= fl_mem[pj];
        end
        if (cmd.write)
        begin
            sp_mem[pos_reg[IDX_W-1:0]] <= sp_reg;
            ep_mem[pos_reg[IDX_W-1:0]] <= ep_reg;
            fl_mem[pos_reg[IDX_W-1:0]] <= req_reg.flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.decode && req_reg.func == FUNC_CLEAR)
            count_reg <= '0;
        else if (cmd.write)
            count_reg <= count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= in_word;
        if (cmd.decode)
        begin
            idx_reg <= '0;
            found_reg <= 1'b0;
            pos_found_reg <= 1'b0;
            pos_reg <= count_reg;
            sp_reg <= req_reg.addr[ADDR_BITS-1:PAGE_SHIFT];
            ep_reg <= ep_c[PAGE_W-1:0];
            cur_reg <= {1'b0, req_reg.addr};
            end_reg <= sum;
            steps_reg <= '0;
            chk_done_reg <= chk_bad;
            res_reg <= dec_res;
            early_reg <= map_bad || chk_bad || (req_reg.func == FUNC_CLEAR);
        end
        if (cmd.scan)
        begin
            idx_reg <= (idx_reg == count_reg) ? count_reg : idx_reg + CNT_W'(1);
            if (req_reg.func == FUNC_MAP)
            begin
                if (in_tab && e_sp < ep_reg && sp_reg < e_ep)
                begin
                    early_reg <= 1'b1;
                    res_reg.status <= ST_OVERLAP;
                end
                if (in_tab && !pos_found_reg && !(e_sp <= sp_reg))
                begin
                    pos_found_reg <= 1'b1;
                    pos_reg <= idx_reg;
                end
                if (idx_reg == count_reg)
                begin
                    if (count_reg == CNT_W'(MAX_REGIONS) && !early_reg)
                    begin
                        early_reg <= 1'b1;
                        res_reg.status <= ST_FULL;
                    end
                end
            end
            else
            begin
                if (in_tab && !found_reg && e_sp <= find_pg && find_pg < e_ep)
                begin
                    found_reg <= 1'b1;
                    res_reg.hit <= 1'b1;
                    res_reg.hit_index <= 4'(ix);
                    res_reg.hit_start <= ADDR_BITS'({e_sp, {PAGE_SHIFT{1'b0}}});
                    res_reg.hit_end <= ADDR_BITS'({e_ep, {PAGE_SHIFT{1'b0}}});
                    res_reg.hit_flags <= e_fl;
                end
                if (idx_reg == count_reg && !found_reg &&
                    !(in_tab && e_sp <= find_pg && find_pg < e_ep))
                    res_reg.status <= ST_NOTFOUND;
            end
        end
        if (cmd.shift)
        begin
            if (idx_reg > pos_reg)
                idx_reg <= idx_reg - CNT_W'(1);
            else
            begin
                res_reg.hit <= 1'b1;
                res_reg.hit_index <= 4'(pos_reg[IDX_W-1:0]);
                res_reg.hit_start <= ADDR_BITS'({sp_reg, {PAGE_SHIFT{1'b0}}});
                res_reg.hit_end <= ADDR_BITS'({ep_reg, {PAGE_SHIFT{1'b0}}});
                res_reg.hit_flags <= req_reg.flags;
            end
        end
        if (cmd.chk_step && !chk_done_reg)
        begin
            if (!(cur_reg < end_reg) || steps_reg > (CNT_W+1)'(MAX_REGIONS))
            begin
                chk_done_reg <= 1'b1;
                res_reg.status <= (cur_reg < end_reg) ? ST_DENIED : ST_OK;
            end
            else if (chk_hold)
            begin
                idx_reg <= '0;
                steps_reg <= steps_reg + (CNT_W+1)'(1);
                cur_reg <= {1'b0, e_ep, {PAGE_SHIFT{1'b0}}};
                if (!(req_reg.is_write ? e_fl[1] : e_fl[0]) ||
                    (req_reg.is_write && e_fl[2] && cur_pg == e_sp))
                begin
                    chk_done_reg <= 1'b1;
                    res_reg.status <= ST_DENIED;
                end
            end
            else if (!in_tab)
            begin
                chk_done_reg <= 1'b1;
                res_reg.status <= ST_DENIED;
            end
            else
                idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    assign st.early = early_reg;
    assign st.scan_end = (idx_reg == count_reg) ||
                         (req_reg.func != FUNC_MAP && found_reg);
    assign st.shift_end = !(idx_reg > pos_reg);
    assign st.chk_done = chk_done_reg;
    assign st.func = req_reg.func;
    assign res = res_reg;
endmodule
`default_nettype wire

/* rtl/core/sorted_region_table.sv */
// sorted_region_table: sorted region table with map, find, check and clear
// map scans the table then shifts entries up; check takes up to 17 span steps,
// visiting up to 16 table entries per step
// throughput: one word at a time, next word taken after the result is handed over
// reset: rst_n async low empties the table and restores the full user window
`default_nettype none
module sorted_region_table (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire srt_pkg::in_word_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output srt_pkg::out_word_t       out_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [63:0]         pwdata,
    output logic [63:0]              prdata,
    output logic                     pready
);
    import srt_pkg::*;

    localparam logic [3:0] ADDR_LOW  = 4'h0;
    localparam logic [3:0] ADDR_HIGH = 4'h8;

    logic [ADDR_BITS-1:0] win_low_reg, win_high_reg;
    cmd_t      cmd;
    stat_t     st;
    out_word_t res;
    logic      idle;
    logic      out_valid_reg;
    out_word_t out_reg;

    assign pready = 1'b1;

    // register writes during access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_low_reg <= '0;
            win_high_reg <= '1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                ADDR_LOW:  win_low_reg <= pwdata[ADDR_BITS-1:0];
                ADDR_HIGH: win_high_reg <= pwdata[ADDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_LOW:  prdata = 64'(win_low_reg);
            ADDR_HIGH: prdata = 64'(win_high_reg);
            default:   prdata = '0;
        endcase
    end

    // accept only when the controller is idle
    assign in_stall = !idle;

    srt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_valid && idle),
        .out_busy(out_valid_reg && out_stall),
        .st      (st),
        .cmd     (cmd),
        .idle    (idle)
    );

    srt_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_word (in_data),
        .win_low (win_low_reg),
        .win_high(win_high_reg),
        .st      (st),
        .res     (res)
    );

    // output word register, next word may start while this one waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed under stall");
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid && out_stall))
        else $error("result overwrote a waiting word");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= ST_DENIED)
        else $error("status code out of range");
endmodule
`default_nettype wire

/* sim/tb_sorted_region_table.sv */
`default_nettype none
module tb_sorted_region_table;
    import srt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [38:0] ADDR_TOP = {39{1'b1}};
    localparam int PG = PAGE_BYTES;
    // register byte addresses (64-bit data, so 8*i)
    localparam logic [3:0] REG_WIN_LOW  = 4'd0;
    localparam logic [3:0] REG_WIN_HIGH = 4'd8;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_word_t in_data;
    logic out_valid;
    logic out_stall;
    out_word_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;

    sorted_region_table dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------
    // predictor: private copy of the region table and the user window
    // ---------------------------------------------------------------
    logic [63:0] win_low;
    logic [63:0] win_high;
    logic [63:0] tbl_start [MAX_REGIONS];
    logic [63:0] tbl_end [MAX_REGIONS];
    logic [2:0]  tbl_flags [MAX_REGIONS];
    int          tbl_count;

    out_word_t expected_words [$];
    int errors;
    int accepted_in;
    int accepted_out;
    int idle_cycles = 0;
    int cnt_find_hit;
    int cnt_denied;

    // first region holding the address's page, or -1 when none does
    function automatic int region_holding(logic [63:0] a);
        logic [63:0] pg;
        pg = a / PG;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_start[i] <= pg && pg < tbl_end[i])
                return i;
        return -1;
    endfunction

    function automatic out_word_t region_word(int i);
        out_word_t w;
        w = '0;
        w.hit = 1'b1;
        w.hit_index = i[3:0];
        w.hit_start = 39'(tbl_start[i] * PG);
        w.hit_end = 39'(tbl_end[i] * PG);
        w.hit_flags = tbl_flags[i];
        return w;
    endfunction

    function automatic out_word_t predict_table_op(in_word_t w);
        out_word_t r;
        logic [63:0] a;
        logic [63:0] len;
        logic [63:0] sum;
        logic [63:0] sp;
        logic [63:0] ep;
        logic [63:0] cur;
        int pos;
        int k;
        logic need;
        r = '0;
        a = 64'(w.addr);
        len = 64'(w.length);
        sum = a + len;
        case (func_t'(w.func))
            FUNC_MAP:
            begin
                sp = a / PG;
                ep = sum / PG + ((sum % PG) != 0 ? 64'd1 : 64'd0);
                if (!(sp < ep && sp * PG >= win_low && ep <= win_high / PG))
                    r.status = ST_WINDOW;
                else
                begin
                    r.status = ST_OK;
                    for (int i = 0; i < tbl_count; i++)
                        if (tbl_start[i] < ep && sp < tbl_end[i])
                            r.status = ST_OVERLAP;
                    if (r.status == ST_OK && tbl_count >= MAX_REGIONS)
                        r.status = ST_FULL;
                    if (r.status == ST_OK)
                    begin
                        pos = 0;
                        while (pos < tbl_count && tbl_start[pos] <= sp)
                            pos++;
                        for (int i = tbl_count; i > pos; i--)
                        begin
                            tbl_start[i] = tbl_start[i-1];
                            tbl_end[i] = tbl_end[i-1];
                            tbl_flags[i] = tbl_flags[i-1];
                        end
                        tbl_start[pos] = sp;
                        tbl_end[pos] = ep;
                        tbl_flags[pos] = w.flags;
                        tbl_count++;
                        r = region_word(pos);
                        r.status = ST_OK;
                    end
                end
            end
            FUNC_FIND:
            begin
                k = region_holding(a);
                if (k < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    r = region_word(k);
                    r.status = ST_OK;
                end
            end
            FUNC_CHECK:
            begin
                if (sum <= a || a < win_low || sum > win_high)
                    r.status = ST_WINDOW;
                else
                begin
                    r.status = ST_OK;
                    cur = a;
                    need = 1'b0;
                    for (int s = 0; s <= MAX_REGIONS && cur < sum && !need; s++)
                    begin
                        k = region_holding(cur);
                        if (k < 0)
                            need = 1'b1;
                        else if (!tbl_flags[k][w.is_write ? 1 : 0])
                            need = 1'b1;
                        else if (w.is_write && tbl_flags[k][2] && cur / PG == tbl_start[k])
                            need = 1'b1;
                        else
                            cur = tbl_end[k] * PG;
                    end
                    if (need || cur < sum)
                        r.status = ST_DENIED;
                end
            end
            default:
            begin
                tbl_count = 0;
                r.status = ST_OK;
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // input driver
    // ---------------------------------------------------------------
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a falling edge; valid stays high across back-to-back words
    task automatic send_word(in_word_t w, logic has_gold, out_word_t gold);
        out_word_t pred;
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = predict_table_op(w);
        if (has_gold && pred !== gold)
        begin
            $error("directed row disagrees with predictor: exp %h pred %h", gold, pred);
            errors++;
        end
        expected_words.push_back(pred);
        accepted_in++;
        @(negedge clk);
    endtask

    // wait for all results, then a margin for the block to settle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_reg(logic [3:0] a, logic [63:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (a == REG_WIN_LOW)
            win_low = 64'(v[38:0]);
        else
            win_high = 64'(v[38:0]);
    endtask

    function automatic in_word_t mk(func_t f, logic [38:0] a, logic [38:0] l,
                                    logic [2:0] fl, logic wr);
        in_word_t w;
        w.func = f;
        w.addr = a;
        w.length = l;
        w.flags = fl;
        w.is_write = wr;
        return w;
    endfunction

    // random word mostly aimed at page numbers the table is likely to hold
    function automatic in_word_t rand_word(int span_pages);
        in_word_t w;
        logic [38:0] base;
        int p;
        p = $urandom_range(0, 99);
        base = 39'(win_low) + 39'($urandom_range(0, span_pages)) * PG
               + 39'($urandom_range(0, PG - 1) & ($urandom_range(0, 1) ? 32'hfff : 32'h0));
        w.addr = base;
        w.length = 39'($urandom_range(0, 4 * PG));
        w.flags = 3'($urandom_range(0, 7));
        w.is_write = 1'($urandom_range(0, 1));
        if (p < 40) w.func = FUNC_MAP;
        else if (p < 65) w.func = FUNC_FIND;
        else if (p < 97) w.func = FUNC_CHECK;
        else w.func = FUNC_CLEAR;
        // noise: full-range fields so every bit toggles
        if ($urandom_range(0, 19) == 0)
        begin
            w.addr = {$urandom, $urandom} & ADDR_TOP;
            w.length = {$urandom, $urandom} & ADDR_TOP;
        end
        return w;
    endfunction

    // ---------------------------------------------------------------
    // output monitor and stall generator
    // ---------------------------------------------------------------
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left <= gap_len();
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            accepted_out++;
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected: %h", out_data);
                errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (out_data.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, out_data.status);
                    errors++;
                end
                if (out_data.hit !== e.hit)
                begin
                    $error("hit exp %0d got %0d", e.hit, out_data.hit);
                    errors++;
                end
                if (out_data.hit_index !== e.hit_index)
                begin
                    $error("hit_index exp %0d got %0d", e.hit_index, out_data.hit_index);
                    errors++;
                end
                if (out_data.hit_start !== e.hit_start)
                begin
                    $error("hit_start exp %h got %h", e.hit_start, out_data.hit_start);
                    errors++;
                end
                if (out_data.hit_end !== e.hit_end)
                begin
                    $error("hit_end exp %h got %h", e.hit_end, out_data.hit_end);
                    errors++;
                end
                if (out_data.hit_flags !== e.hit_flags)
                begin
                    $error("hit_flags exp %0d got %0d", e.hit_flags, out_data.hit_flags);
                    errors++;
                end
                if (e.status == ST_OK && e.hit) cnt_find_hit++;
                if (e.status == ST_DENIED) cnt_denied++;
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("sorted_region_table verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------
    typedef struct {
        in_word_t  w;
        logic      has_gold;
        out_word_t gold;
    } row_t;

    function automatic out_word_t st_only(status_t s);
        out_word_t r;
        r = '0;
        r.status = s;
        return r;
    endfunction

    function automatic out_word_t hit_word(int i, logic [38:0] s, logic [38:0] e,
                                           logic [2:0] f);
        out_word_t r;
        r = '0;
        r.status = ST_OK;
        r.hit = 1'b1;
        r.hit_index = i[3:0];
        r.hit_start = s;
        r.hit_end = e;
        r.hit_flags = f;
        return r;
    endfunction

    row_t directed [$];

    initial
    begin
        in_word_t w;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        accepted_in = 0;
        accepted_out = 0;
        cnt_find_hit = 0;
        cnt_denied = 0;
        win_low = 0;
        win_high = 64'(ADDR_TOP);
        tbl_count = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table after reset, then extremes and every error code but full
        directed.push_back('{mk(FUNC_FIND, 39'd0, 39'd0, 3'd0, 1'b0), 1'b1, st_only(ST_NOTFOUND)});
        directed.push_back('{mk(FUNC_CHECK, 39'd0, 39'd0, 3'd0, 1'b0), 1'b1, st_only(ST_WINDOW)});
        directed.push_back('{mk(FUNC_MAP, 39'h1000, 39'd0, 3'd3, 1'b0), 1'b1, st_only(ST_WINDOW)});
        directed.push_back('{mk(FUNC_MAP, ADDR_TOP, ADDR_TOP, 3'd7, 1'b1), 1'b1, st_only(ST_WINDOW)});
        directed.push_back('{mk(FUNC_MAP, 39'h1001, 39'h1000, 3'd3, 1'b0), 1'b1,
                             hit_word(0, 39'h1000, 39'h3000, 3'd3)});
        directed.push_back('{mk(FUNC_MAP, 39'h2000, 39'h10, 3'd1, 1'b0), 1'b1, st_only(ST_OVERLAP)});
        directed.push_back('{mk(FUNC_MAP, 39'h3000, 39'h2000, 3'd6, 1'b0), 1'b1,
                             hit_word(1, 39'h3000, 39'h5000, 3'd6)});
        directed.push_back('{mk(FUNC_MAP, 39'h0, 39'h1000, 3'd1, 1'b0), 1'b1,
                             hit_word(0, 39'h0, 39'h1000, 3'd1)});
        // highest single page that can be mapped, ending at the top of the window
        directed.push_back('{mk(FUNC_MAP, 39'h7f_ffff_e000, 39'h1000, 3'd7, 1'b0), 1'b0, '0});
        directed.push_back('{mk(FUNC_FIND, 39'h2fff, 39'd0, 3'd0, 1'b0), 1'b0, '0});
        directed.push_back('{mk(FUNC_FIND, 39'h9000, 39'd0, 3'd0, 1'b0), 1'b1, st_only(ST_NOTFOUND)});
        directed.push_back('{mk(FUNC_CHECK, 39'h0, 39'h3000, 3'd0, 1'b0), 1'b0, '0});
        directed.push_back('{mk(FUNC_CHECK, 39'h1000, 39'h2000, 3'd0, 1'b1), 1'b0, '0});
        // write into lowest page of a stack region, then above it
        directed.push_back('{mk(FUNC_CHECK, 39'h3010, 39'h10, 3'd0, 1'b1), 1'b1, st_only(ST_DENIED)});
        directed.push_back('{mk(FUNC_CHECK, 39'h4010, 39'h10, 3'd0, 1'b1), 1'b0, '0});
        directed.push_back('{mk(FUNC_CHECK, 39'h4000, 39'h2000, 3'd0, 1'b0), 1'b1, st_only(ST_DENIED)});
        directed.push_back('{mk(FUNC_CHECK, ADDR_TOP, 39'h2, 3'd0, 1'b0), 1'b1, st_only(ST_WINDOW)});
        directed.push_back('{mk(FUNC_CLEAR, ADDR_TOP, ADDR_TOP, 3'd7, 1'b1), 1'b1, st_only(ST_OK)});
        directed.push_back('{mk(FUNC_FIND, 39'h1000, 39'd0, 3'd0, 1'b0), 1'b1, st_only(ST_NOTFOUND)});
        foreach (directed[i])
            send_word(directed[i].w, directed[i].has_gold, directed[i].gold);
        // fill the table to get the full code, one single-page region on every other page
        for (int i = 0; i < MAX_REGIONS + 1; i++)
            send_word(mk(FUNC_MAP, 39'(i * 2 * PG), 39'(PG), 3'd3, 1'b0), 1'b0, '0);
        send_word(mk(FUNC_CLEAR, 39'd0, 39'd0, 3'd0, 1'b0), 1'b0, '0);
        drain();

        // random phases under several window settings, extremes included
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_WIN_LOW, 64'h0); write_reg(REG_WIN_HIGH, 64'(ADDR_TOP)); end
                1: begin write_reg(REG_WIN_LOW, 64'h40_0000); write_reg(REG_WIN_HIGH, 64'h48_0000); end
                2: begin write_reg(REG_WIN_LOW, 64'h7f_fff0_0000); write_reg(REG_WIN_HIGH, 64'(ADDR_TOP)); end
                default: begin write_reg(REG_WIN_LOW, 64'h1234); write_reg(REG_WIN_HIGH, 64'h3_0000); end
            endcase
            n = 0;
            while (n < 400)
            begin
                w = rand_word(ph == 1 ? 40 : 60);
                send_word(w, 1'b0, '0);
                n++;
            end
            send_word(mk(FUNC_CLEAR, 39'd0, 39'd0, 3'd0, 1'b0), 1'b0, '0);
            drain();
        end

        $display("covered %0d input words, %0d results, %0d region hits, %0d denials",
                 accepted_in, accepted_out, cnt_find_hit, cnt_denied);
        $display("window settings: full, narrow, top of space, unaligned low");
        if (errors == 0 && expected_words.size() == 0)
            $display("sorted_region_table verification clean");
        else
            $display("sorted_region_table verification failed");
        $finish;
    end
endmodule
`default_nettype wire

/* sorted_region_table.f */
rtl/core/srt_pkg.sv
rtl/core/srt_ctrl.sv
rtl/core/srt_dp.sv
rtl/core/sorted_region_table.sv
sim/tb_sorted_region_table.sv
